// ----- rtl/cph_pkg.sv -----
// ----------------------------------------------------------------------------
// cph_pkg: shared types and constants for the constellation pair hasher
// Beat formats, configuration register set, anchor record and pair-test
// result, plus register indexes, record kinds and reset values.
// ----------------------------------------------------------------------------
package cph_pkg;

  // anchor window depth default
  localparam int WINDOW_DEF = 16;

  // field widths
  localparam int TIME_W  = 20;
  localparam int FREQ_W  = 14;
  localparam int COUNT_W = 4;
  localparam int SONG_W  = 31;
  localparam int GAP_W   = 12;
  localparam int BIN_W   = 10;
  localparam int HASH_W  = 32;
  localparam int KIND_W  = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_SONG_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGETS     = 3'd4;

  // register reset values
  localparam logic [SONG_W-1:0]  RST_SONG_ID  = '0;
  localparam logic [GAP_W-1:0]   RST_MIN_GAP  = 12'd5;
  localparam logic [GAP_W-1:0]   RST_MAX_GAP  = 12'd30;
  localparam logic [FREQ_W-1:0]  RST_MAX_FREQ = 14'd480;
  localparam logic [COUNT_W-1:0] RST_TARGETS  = 4'd5;

  // record kinds
  localparam logic [KIND_W-1:0] KIND_HASH     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_HASH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_NONE = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] peak_time;
    logic [FREQ_W-1:0] peak_freq;
    logic              last_peak;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HASH_W-1:0] hash_word;
    logic [TIME_W-1:0] anchor_time;
    logic [SONG_W-1:0] song_tag;
    logic              overflow;
    logic              run_end;
  } out_beat_t;

  typedef struct packed {
    logic [SONG_W-1:0]  song_id;
    logic [GAP_W-1:0]   min_gap_tenths;
    logic [GAP_W-1:0]   max_gap_tenths;
    logic [FREQ_W-1:0]  max_freq_gap;
    logic [COUNT_W-1:0] targets_per_anchor;
  } cfg_regs_t;

  // one anchor slot as stored in the anchor memory
  typedef struct packed {
    logic [TIME_W-1:0]  atime;
    logic [FREQ_W-1:0]  afreq;
    logic [COUNT_W-1:0] count;
  } anchor_t;

  // outcome of one anchor/peak comparison
  typedef struct packed {
    logic               emit;
    logic               retire;
    logic [COUNT_W-1:0] cnt_inc;
    logic [HASH_W-1:0]  hash_word;
  } pair_res_t;

endpackage

// ----- rtl/cph_anchor_mem.sv -----
// ----------------------------------------------------------------------------
// cph_anchor_mem: anchor slot storage
// One write port and one read port with registered read data; holds anchor
// time, frequency and target count for each window slot.
// ----------------------------------------------------------------------------
module cph_anchor_mem
  import cph_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  localparam int SLOT_W = $clog2(WINDOW)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  anchor_t           wr_data,
  input  logic [SLOT_W-1:0] rd_addr,
  output anchor_t           rd_data
);

  anchor_t mem [WINDOW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/cph_pair_eval.sv -----
// ----------------------------------------------------------------------------
// cph_pair_eval: anchor/peak pair test
// Time gap and frequency gap against the configured limits, count check,
// and hash word assembly for one anchor per cycle.
// ----------------------------------------------------------------------------
module cph_pair_eval
  import cph_pkg::*;
(
  input  in_beat_t  peak,
  input  anchor_t   anchor,
  input  cfg_regs_t cfg,
  output pair_res_t res
);

  logic [TIME_W:0]   gap_ext;
  logic [TIME_W-1:0] gap;
  logic              behind;
  logic              too_close;
  logic              too_far;
  logic              full;
  logic [FREQ_W-1:0] fd;
  logic              freq_ok;
  logic              emit;

  // time gap; borrow marks a peak earlier than the anchor
  assign gap_ext   = {1'b0, peak.peak_time} - {1'b0, anchor.atime};
  assign behind    = gap_ext[TIME_W];
  assign gap       = gap_ext[TIME_W-1:0];
  assign too_close = behind || (gap < {{(TIME_W-GAP_W){1'b0}}, cfg.min_gap_tenths});
  assign too_far   = gap > {{(TIME_W-GAP_W){1'b0}}, cfg.max_gap_tenths};
  assign full      = anchor.count >= cfg.targets_per_anchor;

  // absolute frequency difference
  assign fd = (peak.peak_freq >= anchor.afreq) ? (peak.peak_freq - anchor.afreq)
                                               : (anchor.afreq - peak.peak_freq);
  assign freq_ok = fd <= cfg.max_freq_gap;

  assign emit = !too_close && !too_far && !full && freq_ok;

  always_comb begin
    res.emit      = emit;
    res.cnt_inc   = anchor.count + 1'b1;
    res.retire    = !too_close &&
                    (too_far || full || (emit && (res.cnt_inc >= cfg.targets_per_anchor)));
    res.hash_word = {anchor.afreq[FREQ_W-1:FREQ_W-BIN_W],
                     peak.peak_freq[FREQ_W-1:FREQ_W-BIN_W],
                     gap[GAP_W-1:0]};
  end

endmodule

// ----- rtl/cph_ctrl.sv -----
// ----------------------------------------------------------------------------
// cph_ctrl: scan sequencer
// Walks the anchor ring oldest first, one slot a cycle unless a new hash finds
// the pending record blocked, through the shared pair test; holds the pending
// hash record, the output register, the live bits and the per-song state.
// ----------------------------------------------------------------------------
module cph_ctrl
  import cph_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  localparam int SLOT_W = $clog2(WINDOW),
  localparam int K_W    = $clog2(WINDOW + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  // input beats
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  // result beats
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  // configuration
  input  cfg_regs_t         cfg,
  // pair test
  output in_beat_t          peak,
  input  pair_res_t         res,
  // anchor memory
  output logic              mem_we,
  output logic [SLOT_W-1:0] mem_waddr,
  output anchor_t           mem_wdata,
  output logic [SLOT_W-1:0] mem_raddr,
  input  anchor_t           mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_TAIL  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  in_beat_t          peak_r, peak_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic              ev_vld_r, ev_vld_nxt;
  logic [SLOT_W-1:0] ev_slot_r, ev_slot_nxt;
  logic [WINDOW-1:0] live_r, live_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic              any_hash_r, any_hash_nxt;
  logic              evicted_r, evicted_nxt;
  out_beat_t         pend_r, pend_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  out_beat_t         out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  logic              out_free;
  logic              out_load;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] iss_slot;
  logic              k_done;
  logic              ev_live;
  logic              stall_ev;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign peak      = peak_r;
  assign out_free  = !out_vld_r || !out_stall;

  // ring slot for scan step k
  assign slot_sum = {1'b0, oldest_r} + {1'b0, k_r[SLOT_W-1:0]};
  assign iss_slot = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
                    SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : slot_sum[SLOT_W-1:0];
  assign k_done   = (k_r == K_W'(WINDOW));

  // evaluate stage holds while a new hash finds the pending record blocked
  assign ev_live  = ev_vld_r && live_r[ev_slot_r];
  assign stall_ev = (state_r == S_SCAN) && ev_live && res.emit && pend_vld_r && !out_free;

  assign mem_raddr = stall_ev ? ev_slot_r : iss_slot;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    peak_nxt     = peak_r;
    k_nxt        = k_r;
    ev_vld_nxt   = ev_vld_r;
    ev_slot_nxt  = ev_slot_r;
    live_nxt     = live_r;
    oldest_nxt   = oldest_r;
    any_hash_nxt = any_hash_r;
    evicted_nxt  = evicted_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_nxt      = out_r;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = ev_slot_r;
    mem_wdata    = '{atime: mem_rdata.atime, afreq: mem_rdata.afreq, count: res.cnt_inc};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          peak_nxt   = in_data;
          k_nxt      = '0;
          ev_vld_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (!stall_ev) begin
          // finish the slot under test
          if (ev_live) begin
            if (res.retire) begin
              live_nxt[ev_slot_r] = 1'b0;
            end
            if (res.emit) begin
              mem_we       = 1'b1;
              any_hash_nxt = 1'b1;
              if (pend_vld_r) begin
                out_load = 1'b1;
                out_nxt  = pend_r;
              end
              pend_vld_nxt = 1'b1;
              pend_nxt     = '{kind: KIND_HASH, hash_word: res.hash_word,
                               anchor_time: mem_rdata.atime, song_tag: cfg.song_id,
                               overflow: evicted_r, run_end: 1'b0};
            end
          end
          // issue the next slot
          if (k_done) begin
            ev_vld_nxt = 1'b0;
            state_nxt  = S_FLUSH;
          end else begin
            ev_vld_nxt  = 1'b1;
            ev_slot_nxt = iss_slot;
            k_nxt       = k_r + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        // the held hash is the last one of this peak
        if (!pend_vld_r) begin
          state_nxt = S_TAIL;
        end else if (out_free) begin
          out_load         = 1'b1;
          out_nxt          = pend_r;
          out_nxt.run_end  = !peak_r.last_peak;
          pend_vld_nxt     = 1'b0;
          state_nxt        = S_TAIL;
        end
      end

      S_TAIL: begin
        if (peak_r.last_peak) begin
          // end record, then clear the song
          if (out_free) begin
            out_load     = 1'b1;
            out_nxt      = '{kind: (any_hash_r ? KIND_END_HASH : KIND_END_NONE),
                             hash_word: '0, anchor_time: '0, song_tag: cfg.song_id,
                             overflow: evicted_r, run_end: 1'b1};
            live_nxt     = '0;
            oldest_nxt   = '0;
            any_hash_nxt = 1'b0;
            evicted_nxt  = 1'b0;
            state_nxt    = S_IDLE;
          end
        end else begin
          // store the peak as a fresh anchor at the oldest slot
          mem_we    = 1'b1;
          mem_waddr = oldest_r;
          mem_wdata = '{atime: peak_r.peak_time, afreq: peak_r.peak_freq, count: '0};
          if (live_r[oldest_r]) begin
            evicted_nxt = 1'b1;
          end
          live_nxt[oldest_r] = 1'b1;
          oldest_nxt = (oldest_r == SLOT_W'(WINDOW - 1)) ? '0 : oldest_r + 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ev_vld_r   <= 1'b0;
      live_r     <= '0;
      oldest_r   <= '0;
      any_hash_r <= 1'b0;
      evicted_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      ev_vld_r   <= ev_vld_nxt;
      live_r     <= live_nxt;
      oldest_r   <= oldest_nxt;
      any_hash_r <= any_hash_nxt;
      evicted_r  <= evicted_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      k_r        <= k_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    peak_r    <= peak_nxt;
    ev_slot_r <= ev_slot_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ----- rtl/constellation_pair_hasher_unit.sv -----
// Each peak is scanned against every window slot through the single read port
// and shared pair test, then passes a flush and a tail step before the idle
// accept state; a new peak is stalled until the unit is back in idle, and
// result-side stalls hold the scan, the flush and the tail.
// Reset (synchronous, rst_n low) clears anchors, flags, output; regs 0/5/30/480/5.
// ----------------------------------------------------------------------------
// constellation_pair_hasher_unit: landmark pair hashing of spectral peaks
// Configuration registers, anchor memory, pair test and scan sequencer.
// ----------------------------------------------------------------------------
module constellation_pair_hasher_unit
  import cph_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SLOT_W = $clog2(WINDOW);

  cfg_regs_t         cfg_r;
  in_beat_t          peak;
  pair_res_t         res;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  anchor_t           mem_wdata;
  logic [SLOT_W-1:0] mem_raddr;
  anchor_t           mem_rdata;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.song_id            <= RST_SONG_ID;
      cfg_r.min_gap_tenths     <= RST_MIN_GAP;
      cfg_r.max_gap_tenths     <= RST_MAX_GAP;
      cfg_r.max_freq_gap       <= RST_MAX_FREQ;
      cfg_r.targets_per_anchor <= RST_TARGETS;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SONG_ID:  cfg_r.song_id            <= cfg_wdata[SONG_W-1:0];
        CFG_MIN_GAP:  cfg_r.min_gap_tenths     <= cfg_wdata[GAP_W-1:0];
        CFG_MAX_GAP:  cfg_r.max_gap_tenths     <= cfg_wdata[GAP_W-1:0];
        CFG_MAX_FREQ: cfg_r.max_freq_gap       <= cfg_wdata[FREQ_W-1:0];
        CFG_TARGETS:  cfg_r.targets_per_anchor <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cph_anchor_mem #(
    .WINDOW (WINDOW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  cph_pair_eval u_eval (
    .peak   (peak),
    .anchor (mem_rdata),
    .cfg    (cfg_r),
    .res    (res)
  );

  cph_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg_r),
    .peak      (peak),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for constellation_pair_hasher_unit
// Drives peak beats with random sender gaps and receiver stalls. A predictor
// of the anchor window computes the hash and end records for each accepted
// peak, and a monitor compares every result beat against them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cph_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int WINDOW        = WINDOW_DEF;
  localparam int SETTLE_CYCLES = 3 * (WINDOW + 3);
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 40;
  localparam int TIME_MAX      = (1 << TIME_W) - 1;
  localparam int FREQ_MAX      = (1 << FREQ_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state: register copy and anchor ring
  cfg_regs_t          regs;
  logic [TIME_W-1:0]  anc_time [WINDOW];
  logic [FREQ_W-1:0]  anc_freq [WINDOW];
  logic [COUNT_W-1:0] anc_cnt  [WINDOW];
  logic               anc_live [WINDOW];
  int unsigned        anc_head;
  logic               song_hashed;
  logic               song_evicted;
  out_beat_t          pending_hashes[$];

  // run bookkeeping
  int          err_count      = 0;
  int          peaks_sent     = 0;
  int          records_seen   = 0;
  int          songs_closed   = 0;
  int          reg_writes     = 0;
  int          cycle_cnt      = 0;
  int          tx_idle_pct    = 0;
  int          rx_idle_pct    = 0;
  int unsigned hold_seq       = 0;
  int unsigned hold_seen;
  int          hold_left;
  out_beat_t   got_rec;
  out_beat_t   want_rec;

  constellation_pair_hasher_unit #(.WINDOW(WINDOW)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d records outstanding", $time, pending_hashes.size());
      $display("[constellation_pair_hasher_unit] ERROR");
      $finish;
    end
  end

  // receiver stall: random per cycle, or a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result monitor: each accepted beat against the oldest expected record
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_rec = out_data;
      records_seen++;
      if (pending_hashes.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected record, expected none actual %h", $time, got_rec);
      end else begin
        want_rec = pending_hashes.pop_front();
        check_field("kind",        want_rec.kind,        got_rec.kind);
        check_field("hash_word",   want_rec.hash_word,   got_rec.hash_word);
        check_field("anchor_time", want_rec.anchor_time, got_rec.anchor_time);
        check_field("song_tag",    want_rec.song_tag,    got_rec.song_tag);
        check_field("overflow",    want_rec.overflow,    got_rec.overflow);
        check_field("run_end",     want_rec.run_end,     got_rec.run_end);
      end
    end
  end

  task automatic clear_song();
    for (int i = 0; i < WINDOW; i++) anc_live[i] = 1'b0;
    anc_head     = 0;
    song_hashed  = 1'b0;
    song_evicted = 1'b0;
  endtask

  // pair one peak with the live anchors and queue the records it causes
  task automatic pair_peak(input in_beat_t pk);
    int unsigned       s;
    int                made;
    logic [TIME_W-1:0] gap;
    logic [FREQ_W-1:0] fdiff;
    out_beat_t         rec;
    made = 0;
    for (int k = 0; k < WINDOW; k++) begin
      s = (anc_head + k) % WINDOW;
      if (!anc_live[s]) continue;
      // time going backwards counts as too close
      if (pk.peak_time < anc_time[s]) continue;
      gap = pk.peak_time - anc_time[s];
      if (gap < regs.min_gap_tenths) continue;
      if (gap > regs.max_gap_tenths || anc_cnt[s] >= regs.targets_per_anchor) begin
        anc_live[s] = 1'b0;
        continue;
      end
      fdiff = (pk.peak_freq >= anc_freq[s]) ? pk.peak_freq - anc_freq[s]
                                            : anc_freq[s] - pk.peak_freq;
      if (fdiff > regs.max_freq_gap) continue;
      rec             = '0;
      rec.kind        = KIND_HASH;
      rec.hash_word   = {anc_freq[s][FREQ_W-1:4], pk.peak_freq[FREQ_W-1:4], gap[GAP_W-1:0]};
      rec.anchor_time = anc_time[s];
      rec.song_tag    = regs.song_id;
      rec.overflow    = song_evicted;
      pending_hashes  = {pending_hashes, rec};
      made++;
      song_hashed = 1'b1;
      anc_cnt[s]  = anc_cnt[s] + 1'b1;
      if (anc_cnt[s] >= regs.targets_per_anchor) anc_live[s] = 1'b0;
    end
    if (pk.last_peak) begin
      rec            = '0;
      rec.kind       = song_hashed ? KIND_END_HASH : KIND_END_NONE;
      rec.song_tag   = regs.song_id;
      rec.overflow   = song_evicted;
      rec.run_end    = 1'b1;
      pending_hashes = {pending_hashes, rec};
      clear_song();
    end else begin
      // new anchor at the ring head; a live one there is evicted
      s = anc_head;
      if (anc_live[s]) song_evicted = 1'b1;
      anc_time[s] = pk.peak_time;
      anc_freq[s] = pk.peak_freq;
      anc_cnt[s]  = '0;
      anc_live[s] = 1'b1;
      anc_head    = (s + 1) % WINDOW;
      if (made > 0) pending_hashes[pending_hashes.size() - 1].run_end = 1'b1;
    end
  endtask

  // offer one peak beat, with random sender gaps, until it is accepted
  task automatic send_peak(input int tm, input int fq, input logic last);
    in_beat_t pk;
    pk.peak_time = tm[TIME_W-1:0];
    pk.peak_freq = fq[FREQ_W-1:0];
    pk.last_peak = last;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pk;
    do @(posedge clk); while (in_stall);
    pair_peak(pk);
    peaks_sent++;
    if (last) songs_closed++;
  endtask

  // stop offering, wait for every record, then let the scan finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_SONG_ID:  regs.song_id            = val[SONG_W-1:0];
      CFG_MIN_GAP:  regs.min_gap_tenths     = val[GAP_W-1:0];
      CFG_MAX_GAP:  regs.max_gap_tenths     = val[GAP_W-1:0];
      CFG_MAX_FREQ: regs.max_freq_gap       = val[FREQ_W-1:0];
      CFG_TARGETS:  regs.targets_per_anchor = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic random_regs();
    write_reg(CFG_SONG_ID,  CFG_DATA_W'($urandom));
    write_reg(CFG_MIN_GAP,  CFG_DATA_W'($urandom_range(0, 8)));
    write_reg(CFG_MAX_GAP,  CFG_DATA_W'($urandom_range(12, 60)));
    write_reg(CFG_MAX_FREQ, CFG_DATA_W'($urandom_range(64, 2048)));
    write_reg(CFG_TARGETS,  CFG_DATA_W'($urandom_range(1, 15)));
  endtask

  // one song: mostly small forward steps near a base frequency, with some
  // backward steps, long jumps and far-off frequencies mixed in
  task automatic run_song(input int n);
    int tm, fq, base, step;
    tm   = ($urandom_range(3) == 0) ? $urandom_range(TIME_MAX - 500, TIME_MAX)
                                    : $urandom_range(0, TIME_MAX);
    base = $urandom_range(0, FREQ_MAX);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       step = -$urandom_range(1, 6);
        1:       step = $urandom_range(40, 120);
        default: step = $urandom_range(0, 9);
      endcase
      tm = tm + step;
      if (tm < 0) tm = 0;
      if (tm > TIME_MAX) tm = TIME_MAX;
      if ($urandom_range(4) == 0) fq = $urandom_range(0, FREQ_MAX);
      else fq = base + $urandom_range(0, 1200) - 600;
      if (fq < 0) fq = 0;
      if (fq > FREQ_MAX) fq = FREQ_MAX;
      send_peak(tm, fq, i == n - 1);
    end
  endtask

  // reset register values: skip, retire, time going backwards, end with hashes
  task automatic test_defaults();
    send_peak(100, 16'h3FF0, 1'b0);
    send_peak(50,  16'h3FF0, 1'b0);
    send_peak(130, 16'h3E20, 1'b0);
    send_peak(131, 0,        1'b1);
  endtask

  // full window: eviction sets overflow, then a peak hashing with every slot
  task automatic test_window_overflow();
    settle();
    for (int i = 0; i <= WINDOW; i++) send_peak(TIME_MAX - 15, i * 30, 1'b0);
    send_peak(TIME_MAX - 5, 240, 1'b0);
    send_peak(TIME_MAX,     240, 1'b1);
  endtask

  // a target limit of zero retires every anchor unpaired
  task automatic test_zero_target_limit();
    settle();
    write_reg(CFG_TARGETS, '0);
    send_peak(0,  0, 1'b0);
    send_peak(10, 0, 1'b0);
    send_peak(20, 0, 1'b1);
  endtask

  // register extremes, masking of wide data, unused indexes ignored
  task automatic test_register_extremes();
    settle();
    write_reg(CFG_SONG_ID,  '1);
    write_reg(CFG_MIN_GAP,  '0);
    write_reg(CFG_MAX_GAP,  '1);
    write_reg(CFG_MAX_FREQ, '1);
    write_reg(CFG_TARGETS,  '1);
    for (int i = CFG_TARGETS + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
    send_peak(0,    0,        1'b0);
    send_peak(0,    FREQ_MAX, 1'b0);
    send_peak(4095, 16'h2AAA, 1'b1);
    settle();
    write_reg(CFG_MIN_GAP, '1);
    write_reg(CFG_MAX_GAP, '0);
    send_peak(0,    FREQ_MAX, 1'b0);
    send_peak(4095, 0,        1'b1);
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    int tm;
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_MIN_GAP,  CFG_DATA_W'(1));
    write_reg(CFG_MAX_GAP,  CFG_DATA_W'(200));
    write_reg(CFG_MAX_FREQ, '1);
    write_reg(CFG_TARGETS,  '1);
    tm = $urandom_range(0, TIME_MAX - 100);
    hold_seq++;
    for (int i = 0; i < 14; i++) begin
      tm = tm + $urandom_range(1, 3);
      send_peak(tm, $urandom_range(0, FREQ_MAX), i == 13);
    end
    settle();
  endtask

  // random songs in three idling modes, new register values in each
  task automatic test_random_phases();
    int goal;
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 80 : 0;
      rx_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 6 : 0;
      random_regs();
      goal = peaks_sent + 16;
      while (peaks_sent < goal) run_song($urandom_range(3, 10));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    regs.song_id            = RST_SONG_ID;
    regs.min_gap_tenths     = RST_MIN_GAP;
    regs.max_gap_tenths     = RST_MAX_GAP;
    regs.max_freq_gap       = RST_MAX_FREQ;
    regs.targets_per_anchor = RST_TARGETS;
    clear_song();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 6;
    rx_idle_pct = 80;
    test_defaults();
    test_window_overflow();
    test_zero_target_limit();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    settle();

    $display("Covered %0d peaks in %0d songs, %0d records checked, %0d register writes,",
             peaks_sent, songs_closed, records_seen, reg_writes);
    $display("window eviction, zero and full limits, a long result hold-off and three idle mixes.");
    if (err_count == 0) begin
      $display("[constellation_pair_hasher_unit] OK");
    end else begin
      $display("[constellation_pair_hasher_unit] ERROR");
    end
    $finish;
  end

endmodule
